### design/akat_pkg.sv
// Shared types, constants and register codes for the analog key actuation tracker.
package akat_pkg;

    localparam int NUM_KEYS    = 128;
    localparam int KEY_BITS    = $clog2(NUM_KEYS);
    localparam int SAMPLE_BITS = 12;
    localparam int CFG_BITS    = 12;
    localparam int STEP_BITS   = 10;
    localparam int CLASS_BITS  = 4;
    localparam int PADDR_BITS  = 5;
    localparam int PDATA_BITS  = 32;
    localparam int PROD_BITS   = STEP_BITS + CLASS_BITS;
    localparam int IVL_BITS    = PROD_BITS + 1;

    localparam logic [CFG_BITS-1:0]  VALID_LOW_RST     = CFG_BITS'(50);
    localparam logic [CFG_BITS-1:0]  VALID_HIGH_RST    = CFG_BITS'(3000);
    localparam logic [CFG_BITS-1:0]  HYSTERESIS_RST    = CFG_BITS'(100);
    localparam logic [CFG_BITS-1:0]  INTERVAL_BASE_RST = CFG_BITS'(50);
    localparam logic [STEP_BITS-1:0] INTERVAL_STEP_RST = STEP_BITS'(166);
    localparam logic [SAMPLE_BITS-1:0] LOWEST_RST      = SAMPLE_BITS'(3000);

    typedef enum logic [2:0] {
        REG_VALID_LOW     = 3'd0,
        REG_VALID_HIGH    = 3'd1,
        REG_HYSTERESIS    = 3'd2,
        REG_INTERVAL_BASE = 3'd3,
        REG_INTERVAL_STEP = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        PH_OFF       = 2'd0,
        PH_PRESSING  = 2'd1,
        PH_ON        = 2'd2,
        PH_RELEASING = 2'd3
    } t_phase;

    typedef struct packed {
        logic [CFG_BITS-1:0]  valid_low;
        logic [CFG_BITS-1:0]  valid_high;
        logic [CFG_BITS-1:0]  hysteresis;
        logic [CFG_BITS-1:0]  interval_base;
        logic [STEP_BITS-1:0] interval_step;
    } t_cfg;

    typedef struct packed {
        t_phase                 phase;
        logic [SAMPLE_BITS-1:0] lowest;
        logic [SAMPLE_BITS-1:0] reference;
        logic [SAMPLE_BITS-1:0] trigger;
    } t_key_state;

    localparam t_key_state KEY_STATE_RST = '{
        phase:     PH_OFF,
        lowest:    LOWEST_RST,
        reference: '0,
        trigger:   '0
    };

endpackage

### design/akat_if.sv
// Input and result channel interfaces with valid/ready handshake.
interface akat_in_if;
    logic                              valid;
    logic                              ready;
    logic [akat_pkg::KEY_BITS-1:0]     key_index;
    logic [akat_pkg::SAMPLE_BITS-1:0]  sample;
    logic [akat_pkg::CLASS_BITS-1:0]   interval_class;

    modport source (output valid, key_index, sample, interval_class, input ready);
    modport sink   (input valid, key_index, sample, interval_class, output ready);
endinterface

interface akat_out_if;
    logic                          valid;
    logic                          ready;
    logic [akat_pkg::KEY_BITS-1:0] key_index_out;
    logic                          key_pressed;

    modport source (output valid, key_index_out, key_pressed, input ready);
    modport sink   (input valid, key_index_out, key_pressed, output ready);
endinterface

### design/analog_key_actuation_tracker_core.sv
// Top level: input stage, state memory read, phase update and result register.
// Each accepted input beat passes the stage-1 and result registers in turn.
// Throughput: one beat per cycle unless the output stalls, set by the state
// memory read-modify-write with a forward path for back-to-back same-key beats.
// Reset: synchronous active-low; all keys return to off with lowest sample 3000
// through per-entry valid bits, and registers take their default values at once.
module analog_key_actuation_tracker_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    akat_in_if.sink                         in_ch,
    akat_out_if.source                      out_ch,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [akat_pkg::PADDR_BITS-1:0] paddr,
    input  logic [akat_pkg::PDATA_BITS-1:0] pwdata,
    output logic [akat_pkg::PDATA_BITS-1:0] prdata,
    output logic                            pready
);
    import akat_pkg::*;

    t_cfg                   cfg;
    logic                   pipe_en;
    logic                   accept;
    logic                   r_s1_valid;
    logic [KEY_BITS-1:0]    r_s1_key;
    logic [SAMPLE_BITS-1:0] r_s1_sample;
    logic [CLASS_BITS-1:0]  r_s1_class;
    logic                   r_byp;
    t_key_state             r_byp_state;
    t_key_state             mem_rd;
    t_key_state             cur_state;
    t_key_state             upd_state;
    logic                   upd_wr;
    logic                   upd_down;
    logic                   mem_wr;
    logic                   n_byp;
    logic                   r_out_valid;
    logic [KEY_BITS-1:0]    r_out_key;
    logic                   r_out_down;

    akat_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign pipe_en     = !r_out_valid || out_ch.ready;
    assign in_ch.ready = pipe_en && i_rst_n;
    assign accept      = in_ch.valid && in_ch.ready;
    assign mem_wr      = r_s1_valid && pipe_en && upd_wr;
    assign n_byp       = mem_wr && (r_s1_key == in_ch.key_index);
    assign cur_state   = r_byp ? r_byp_state : mem_rd;

    akat_state_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (in_ch.key_index),
        .i_wr_en   (mem_wr),
        .i_wr_addr (r_s1_key),
        .i_wr_data (upd_state),
        .o_rd_data (mem_rd)
    );

    akat_update u_update (
        .i_cfg         (cfg),
        .i_state       (cur_state),
        .i_sample      (r_s1_sample),
        .i_class       (r_s1_class),
        .o_wr_en       (upd_wr),
        .o_state       (upd_state),
        .o_key_pressed (upd_down)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_byp       <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (pipe_en) begin
            r_s1_valid  <= in_ch.valid;
            r_out_valid <= r_s1_valid;
            if (accept) begin
                r_byp <= n_byp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_key    <= in_ch.key_index;
            r_s1_sample <= in_ch.sample;
            r_s1_class  <= in_ch.interval_class;
            r_byp_state <= upd_state;
        end
        if (pipe_en && r_s1_valid) begin
            r_out_key  <= r_s1_key;
            r_out_down <= upd_down;
        end
    end

    assign out_ch.valid         = r_out_valid;
    assign out_ch.key_index_out = r_out_key;
    assign out_ch.key_pressed   = r_out_down;

endmodule

### design/akat_cfg.sv
// APB-style configuration register file.
module akat_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [akat_pkg::PADDR_BITS-1:0] paddr,
    input  logic [akat_pkg::PDATA_BITS-1:0] pwdata,
    output logic [akat_pkg::PDATA_BITS-1:0] prdata,
    output logic                            pready,
    output akat_pkg::t_cfg                  o_cfg
);
    import akat_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr;

    assign idx    = t_reg_idx'(paddr[PADDR_BITS-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.valid_low     <= VALID_LOW_RST;
            r_cfg.valid_high    <= VALID_HIGH_RST;
            r_cfg.hysteresis    <= HYSTERESIS_RST;
            r_cfg.interval_base <= INTERVAL_BASE_RST;
            r_cfg.interval_step <= INTERVAL_STEP_RST;
        end else if (wr) begin
            case (idx)
                REG_VALID_LOW:     r_cfg.valid_low     <= pwdata[CFG_BITS-1:0];
                REG_VALID_HIGH:    r_cfg.valid_high    <= pwdata[CFG_BITS-1:0];
                REG_HYSTERESIS:    r_cfg.hysteresis    <= pwdata[CFG_BITS-1:0];
                REG_INTERVAL_BASE: r_cfg.interval_base <= pwdata[CFG_BITS-1:0];
                REG_INTERVAL_STEP: r_cfg.interval_step <= pwdata[STEP_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_VALID_LOW:     prdata = PDATA_BITS'(r_cfg.valid_low);
            REG_VALID_HIGH:    prdata = PDATA_BITS'(r_cfg.valid_high);
            REG_HYSTERESIS:    prdata = PDATA_BITS'(r_cfg.hysteresis);
            REG_INTERVAL_BASE: prdata = PDATA_BITS'(r_cfg.interval_base);
            REG_INTERVAL_STEP: prdata = PDATA_BITS'(r_cfg.interval_step);
            default:           prdata = '0;
        endcase
    end

endmodule

### design/akat_state_mem.sv
// Per-key state memory with registered read and per-entry valid bits.
module akat_state_mem (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [akat_pkg::KEY_BITS-1:0] i_rd_addr,
    input  logic                          i_wr_en,
    input  logic [akat_pkg::KEY_BITS-1:0] i_wr_addr,
    input  akat_pkg::t_key_state          i_wr_data,
    output akat_pkg::t_key_state          o_rd_data
);
    import akat_pkg::*;

    t_key_state          r_mem [NUM_KEYS];
    logic [NUM_KEYS-1:0] r_valid;
    t_key_state          r_rd_q;
    logic                r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_q <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_hit <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_hit ? r_rd_q : KEY_STATE_RST;

endmodule

### design/akat_update.sv
// Next-state logic of one key's actuation phase machine.
module akat_update (
    input  akat_pkg::t_cfg                   i_cfg,
    input  akat_pkg::t_key_state             i_state,
    input  logic [akat_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic [akat_pkg::CLASS_BITS-1:0]  i_class,
    output logic                             o_wr_en,
    output akat_pkg::t_key_state             o_state,
    output logic                             o_key_pressed
);
    import akat_pkg::*;

    logic [SAMPLE_BITS-1:0] v;
    logic [PROD_BITS-1:0]   prod;
    logic [IVL_BITS-1:0]    interval;
    logic [SAMPLE_BITS-1:0] lo;
    logic [SAMPLE_BITS-1:0] rf;
    logic [SAMPLE_BITS:0]   lo_hyst;
    logic [SAMPLE_BITS:0]   v_hyst;
    logic [IVL_BITS:0]      ref_ivl;
    logic [IVL_BITS:0]      trig_ivl;
    t_phase                 ph;

    assign v        = i_sample;
    assign prod     = PROD_BITS'(i_cfg.interval_step) * PROD_BITS'(i_class);
    assign interval = IVL_BITS'(i_cfg.interval_base) + IVL_BITS'(prod);
    assign lo       = (i_state.lowest > v) ? v : i_state.lowest;
    assign rf       = (i_state.reference == '0) ? v : i_state.reference;
    assign lo_hyst  = (SAMPLE_BITS+1)'(lo) + (SAMPLE_BITS+1)'(i_cfg.hysteresis);
    assign v_hyst   = (SAMPLE_BITS+1)'(v) + (SAMPLE_BITS+1)'(i_cfg.hysteresis);
    assign ref_ivl  = (IVL_BITS+1)'(rf) + (IVL_BITS+1)'(interval);
    assign trig_ivl = (IVL_BITS+1)'(i_state.trigger) + (IVL_BITS+1)'(interval);
    assign o_wr_en  = (v >= i_cfg.valid_low) && (v <= i_cfg.valid_high);

    always_comb begin
        o_state           = i_state;
        o_state.lowest    = lo;
        o_state.reference = rf;
        case (i_state.phase)
            PH_OFF: begin
                if ((SAMPLE_BITS+1)'(v) > lo_hyst) begin
                    o_state.phase     = PH_PRESSING;
                    o_state.reference = v;
                end
            end
            PH_PRESSING: begin
                if ((IVL_BITS+1)'(v) > ref_ivl) begin
                    o_state.phase   = PH_ON;
                    o_state.trigger = v;
                end else if (v < rf) begin
                    o_state.phase     = PH_OFF;
                    o_state.reference = v;
                end
            end
            PH_ON: begin
                if (v_hyst < (SAMPLE_BITS+1)'(i_state.trigger)) begin
                    o_state.phase = PH_RELEASING;
                end
            end
            PH_RELEASING: begin
                if ((IVL_BITS+1)'(v) < trig_ivl) begin
                    o_state.phase = PH_OFF;
                end
            end
            default: ;
        endcase
    end

    assign ph            = o_wr_en ? o_state.phase : i_state.phase;
    assign o_key_pressed = (ph == PH_ON) || (ph == PH_RELEASING);

endmodule
